// File: hdl/pixel_run_length_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel run-length encoder
// Shared concurrent assertion forms, clocked on clock and idle in reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_RUN_LENGTH_ENCODER_TOP_DEFINES_SVH
`define PIXEL_RUN_LENGTH_ENCODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRLE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/prle_pkg.sv
// ----------------------------------------------------------------------------
// Pixel run-length encoder package
// Shared constants, packet descriptors and pixel helpers.
// ----------------------------------------------------------------------------
package prle_pkg;

   localparam int PIX_W       = 32;
   localparam int LANES       = 4;
   localparam int RUN_W       = 7;
   localparam int CNT_W       = 3;
   localparam int HDR_W       = 8;
   localparam int MAX_RUN_DEF = 127;

   localparam logic [HDR_W-1:0] HDR_REPEAT = 8'h80;

   // Packet kinds
   localparam logic [1:0] PKT_NONE = 2'd0;
   localparam logic [1:0] PKT_LIT  = 2'd1;
   localparam logic [1:0] PKT_REP  = 2'd2;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [LANES-1:0][PIX_W-1:0] row_type;

   // One packet to be sent. For a literal, tail marks that its last pixel
   // is carried here rather than read from the store.
   typedef struct packed {
      logic [1:0]       kind;
      logic [RUN_W-1:0] count;
      logic             tail;
      pixel_type        pixel;
   } pkt_type;

   typedef struct packed {
      pkt_type pkt_a;
      pkt_type pkt_b;
   } job_type;

   typedef struct packed {
      logic             en;
      logic [RUN_W-1:0] index;
      pixel_type        data;
   } wr_req_type;

   typedef struct packed {
      logic             en;
      logic [RUN_W-1:0] index;
   } rd_req_type;

   typedef struct packed {
      logic             has_header;
      logic [HDR_W-1:0] header_byte;
      logic [CNT_W-1:0] pixel_count;
      row_type          slots;
      logic             last_of_burst;
   } rsp_type;

   function automatic pixel_type visible(pixel_type p, logic with_alpha);
      return with_alpha ? p : {8'h00, p[23:0]};
   endfunction

endpackage

// File: hdl/prle_if.sv
// ----------------------------------------------------------------------------
// Pixel run-length encoder channels
// Valid/ready interfaces for the pixel input and the packet output.
// ----------------------------------------------------------------------------
interface prle_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel;
   logic        end_of_image;

   modport source (output valid, output pixel, output end_of_image, input ready);
   modport sink   (input valid, input pixel, input end_of_image, output ready);
endinterface

interface prle_rsp_if;
   logic        valid;
   logic        ready;
   logic        has_header;
   logic [7:0]  header_byte;
   logic [2:0]  pixel_count;
   logic [31:0] pixel_slot0;
   logic [31:0] pixel_slot1;
   logic [31:0] pixel_slot2;
   logic [31:0] pixel_slot3;
   logic        last_of_burst;

   modport source (output valid, output has_header, output header_byte,
                   output pixel_count, output pixel_slot0, output pixel_slot1,
                   output pixel_slot2, output pixel_slot3, output last_of_burst,
                   input ready);
   modport sink   (input valid, input has_header, input header_byte,
                   input pixel_count, input pixel_slot0, input pixel_slot1,
                   input pixel_slot2, input pixel_slot3, input last_of_burst,
                   output ready);
endinterface

// File: hdl/prle_store.sv
// ----------------------------------------------------------------------------
// Literal pixel store
// Row-organised memory, four pixels a row, lane writes and registered reads.
// ----------------------------------------------------------------------------
module prle_store #(
   parameter int MAX_RUN = prle_pkg::MAX_RUN_DEF
) (
   input  logic                   clock,
   input  prle_pkg::wr_req_type   wr_req,
   input  prle_pkg::rd_req_type   rd_req,
   output prle_pkg::row_type      rd_data
);
   import prle_pkg::*;

   localparam int ROWS  = (MAX_RUN + LANES - 1) / LANES;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   row_type mem [ROWS];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.index[ROW_W+1:2]][wr_req.index[1:0]] <= wr_req.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_data_ff <= mem[rd_req.index[ROW_W+1:2]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/prle_plan.sv
// ----------------------------------------------------------------------------
// Run planner
// Holds the lookahead pixel and open run, and plans the packets per pixel.
// ----------------------------------------------------------------------------
module prle_plan #(
   parameter int MAX_RUN = prle_pkg::MAX_RUN_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [31:0]            pixel,
   input  logic                   end_of_image,
   input  logic                   with_alpha,
   output prle_pkg::job_type      job,
   output prle_pkg::wr_req_type   wr_req
);
   import prle_pkg::*;

   localparam logic [RUN_W-1:0] MAX_R = RUN_W'(MAX_RUN);

   pixel_type        held_ff, held_in;
   logic             held_valid_ff, held_valid_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic             repeat_ff, repeat_in;

   logic             same;
   logic [RUN_W-1:0] run_mid;
   logic [RUN_W-1:0] run_app;
   logic             repeat_mid;

   always_comb begin
      same       = visible(held_ff, with_alpha) == visible(pixel, with_alpha);
      run_mid    = run_ff;
      repeat_mid = repeat_ff;
      run_app    = (run_ff < MAX_R) ? run_ff + RUN_W'(1) : run_ff;
      job        = '0;
      wr_req     = '0;

      if (held_valid_ff) begin
         if (repeat_ff) begin
            if (same && run_ff < MAX_R) begin
               run_mid = run_ff + RUN_W'(1);
            end else begin
               job.pkt_a.kind  = PKT_REP;
               job.pkt_a.count = run_ff;
               job.pkt_a.pixel = held_ff;
               repeat_mid      = 1'b0;
               run_mid         = '0;
            end
         end else if (!same) begin
            wr_req.en    = accept && (run_ff < MAX_R);
            wr_req.index = run_ff;
            wr_req.data  = held_ff;
            if (run_app >= MAX_R) begin
               // The literal is full: its last pixel is the one written now.
               job.pkt_a.kind  = PKT_LIT;
               job.pkt_a.count = run_app;
               job.pkt_a.tail  = 1'b1;
               job.pkt_a.pixel = held_ff;
               run_mid         = '0;
            end else begin
               run_mid = run_app;
            end
         end else begin
            if (run_ff != '0) begin
               job.pkt_a.kind  = PKT_LIT;
               job.pkt_a.count = run_ff;
            end
            repeat_mid = 1'b1;
            run_mid    = RUN_W'(2);
         end
      end

      if (end_of_image) begin
         if (repeat_mid) begin
            job.pkt_b.kind  = PKT_REP;
            job.pkt_b.count = run_mid;
            job.pkt_b.pixel = pixel;
         end else begin
            // The final pixel closes the literal, carried in the descriptor.
            job.pkt_b.kind  = PKT_LIT;
            job.pkt_b.count = (run_mid < MAX_R) ? run_mid + RUN_W'(1) : run_mid;
            job.pkt_b.tail  = run_mid < MAX_R;
            job.pkt_b.pixel = pixel;
         end
      end

      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      run_in        = run_ff;
      repeat_in     = repeat_ff;
      if (accept) begin
         if (end_of_image) begin
            held_in       = '0;
            held_valid_in = 1'b0;
            run_in        = '0;
            repeat_in     = 1'b0;
         end else begin
            held_in       = pixel;
            held_valid_in = 1'b1;
            run_in        = run_mid;
            repeat_in     = repeat_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         run_ff        <= '0;
         repeat_ff     <= 1'b0;
      end else begin
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         run_ff        <= run_in;
         repeat_ff     <= repeat_in;
      end
   end

endmodule

// File: hdl/prle_emit.sv
// ----------------------------------------------------------------------------
// Packet emitter
// Sends the planned packets as results, reading literal rows from the store.
// ----------------------------------------------------------------------------
`include "pixel_run_length_encoder_top_defines.svh"

module prle_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  prle_pkg::job_type      job,
   input  logic                   with_alpha,
   output logic                   busy,
   output prle_pkg::rd_req_type   rd_req,
   input  prle_pkg::row_type      rd_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output prle_pkg::rsp_type      rsp_data
);
   import prle_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PKT  = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   logic [1:0]       state_ff, state_in;
   job_type          job_ff, job_in;
   logic             phase_ff, phase_in;
   logic [RUN_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   pkt_type          cur;
   logic             final_pkt;
   logic [RUN_W-1:0] remain;
   logic             last_chunk;
   logic [CNT_W-1:0] chunk;
   logic             slot_free;
   logic             pkt_done;
   logic [RUN_W:0]   pos;
   logic [RUN_W:0]   tail_pos;
   pixel_type        slot_pix;

   always_comb begin
      cur        = phase_ff ? job_ff.pkt_b : job_ff.pkt_a;
      final_pkt  = phase_ff || (job_ff.pkt_b.kind == PKT_NONE);
      remain     = cur.count - idx_ff;
      last_chunk = remain <= RUN_W'(LANES);
      chunk      = last_chunk ? CNT_W'(remain) : CNT_W'(LANES);
      slot_free  = !out_valid_ff || rsp_ready;
      tail_pos   = (RUN_W+1)'(cur.count) - (RUN_W+1)'(1);
      pos        = '0;
      slot_pix   = '0;

      state_in     = state_ff;
      job_in       = job_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      rd_req       = '0;
      pkt_done     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               job_in   = job;
               phase_in = job.pkt_a.kind == PKT_NONE;
               idx_in   = '0;
               if (job.pkt_a.kind != PKT_NONE || job.pkt_b.kind != PKT_NONE) begin
                  state_in = ST_PKT;
               end
            end
         end
         ST_PKT: begin
            if (slot_free) begin
               case (cur.kind)
                  PKT_REP: begin
                     out_in.has_header    = 1'b1;
                     out_in.header_byte   = HDR_REPEAT | HDR_W'(cur.count);
                     out_in.pixel_count   = CNT_W'(1);
                     out_in.slots         = '0;
                     out_in.slots[0]      = visible(cur.pixel, with_alpha);
                     out_in.last_of_burst = final_pkt;
                     out_valid_in         = 1'b1;
                     pkt_done             = 1'b1;
                  end
                  PKT_LIT: begin
                     rd_req.en    = 1'b1;
                     rd_req.index = idx_ff;
                     state_in     = ST_READ;
                  end
                  default: begin
                     pkt_done = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            // The output register was freed when the read was issued.
            out_in.has_header    = idx_ff == '0;
            out_in.header_byte   = (idx_ff == '0) ? HDR_W'(cur.count) : '0;
            out_in.pixel_count   = chunk;
            out_in.last_of_burst = last_chunk && final_pkt;
            for (int j = 0; j < LANES; j++) begin
               pos = (RUN_W+1)'(idx_ff) + (RUN_W+1)'(j);
               if (CNT_W'(j) < chunk) begin
                  slot_pix = (cur.tail && pos == tail_pos) ? cur.pixel : rd_data[j];
                  out_in.slots[j] = visible(slot_pix, with_alpha);
               end else begin
                  out_in.slots[j] = '0;
               end
            end
            out_valid_in = 1'b1;
            if (last_chunk) begin
               pkt_done = 1'b1;
            end else begin
               idx_in   = idx_ff + RUN_W'(LANES);
               state_in = ST_PKT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (pkt_done) begin
         if (final_pkt) begin
            state_in = ST_IDLE;
         end else begin
            phase_in = 1'b1;
            idx_in   = '0;
            state_in = ST_PKT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `PRLE_ASSERT_SAME(a_read_slot_free, state_ff == ST_READ, !out_valid_ff, "read lands on a full output register")
   `PRLE_ASSERT_SAME(a_count_range, out_valid_ff, out_ff.pixel_count != '0 && out_ff.pixel_count <= CNT_W'(LANES), "bad pixel count")
   `PRLE_ASSERT_SAME(a_header_zero, out_valid_ff && !out_ff.has_header, out_ff.header_byte == '0, "header byte without header")
   `PRLE_ASSERT_NEXT(a_read_follows, rd_req.en, state_ff == ST_READ, "store read without capture")

endmodule

// File: hdl/pixel_run_length_encoder_top.sv
// ----------------------------------------------------------------------------
// Pixel run-length encoder, top level
// Packs a pixel stream into literal and repeat packets of up to 127 pixels.
// ----------------------------------------------------------------------------
// Usage. Pixels arrive on req_port, one per transaction, with end_of_image
// set on the final pixel of an image. Packets leave on rsp_port as results
// of up to four pixels; the first result of a packet carries its header
// byte, and last_of_burst marks the final result caused by one pixel.
// csr_we writes csr_wdata into with_alpha; write it only while idle.
//
// Emitter flow. One pixel is accepted whenever the emitter is idle; a
// pixel that closes no packet leaves it idle. A repeat packet is written
// to the output register from ST_PKT. A literal packet is sent in results
// of up to four pixels, each one a read of a four-pixel row from the
// store in ST_PKT and its capture into the output register in ST_READ.
// ST_PKT waits while the output register is full and not taken.
//
// Reset clears the lookahead pixel, the open run and the output valid flag;
// the literal store needs no clearing, as every entry is written before it
// is read. When the receiver stalls the result register holds and the
// emitter waits, so no further pixel is accepted until the burst is in the output register.
// ----------------------------------------------------------------------------
module pixel_run_length_encoder_top #(
   parameter int MAX_RUN = prle_pkg::MAX_RUN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   prle_req_if.sink    req_port,
   prle_rsp_if.source  rsp_port,
   input  logic        csr_we,
   input  logic        csr_wdata
);
   import prle_pkg::*;

   // Configuration register: selects four-channel comparison and output.
   logic with_alpha_ff, with_alpha_in;

   logic       accept;
   logic       emit_busy;
   job_type    job;
   wr_req_type wr_req;
   rd_req_type rd_req;
   row_type    rd_data;
   logic       rsp_valid;
   rsp_type    rsp_data;

   always_comb begin
      with_alpha_in = csr_we ? csr_wdata : with_alpha_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         with_alpha_ff <= 1'b0;
      end else begin
         with_alpha_ff <= with_alpha_in;
      end
   end

   // A pixel is taken only when the previous burst has been handed to the
   // output register in full, so one planned job is in flight at a time.
   assign req_port.ready = !emit_busy;
   assign accept         = req_port.valid && !emit_busy;

   // Lookahead and run state; plans up to two packets per pixel.
   prle_plan #(
      .MAX_RUN (MAX_RUN)
   ) u_plan (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pixel        (req_port.pixel),
      .end_of_image (req_port.end_of_image),
      .with_alpha   (with_alpha_ff),
      .job          (job),
      .wr_req       (wr_req)
   );

   // Literal pixels waiting for their packet to close.
   prle_store #(
      .MAX_RUN (MAX_RUN)
   ) u_store (
      .clock   (clock),
      .wr_req  (wr_req),
      .rd_req  (rd_req),
      .rd_data (rd_data)
   );

   // Walks the planned packets and fills the result register.
   prle_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .job        (job),
      .with_alpha (with_alpha_ff),
      .busy       (emit_busy),
      .rd_req     (rd_req),
      .rd_data    (rd_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_port.ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_port.valid         = rsp_valid;
   assign rsp_port.has_header    = rsp_data.has_header;
   assign rsp_port.header_byte   = rsp_data.header_byte;
   assign rsp_port.pixel_count   = rsp_data.pixel_count;
   assign rsp_port.pixel_slot0   = rsp_data.slots[0];
   assign rsp_port.pixel_slot1   = rsp_data.slots[1];
   assign rsp_port.pixel_slot2   = rsp_data.slots[2];
   assign rsp_port.pixel_slot3   = rsp_data.slots[3];
   assign rsp_port.last_of_burst = rsp_data.last_of_burst;

endmodule
